FILE: design/complex_arithmetic_unit_core_macros.svh
// assertion macros shared by the complex alu
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define CAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define CAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: design/cau_pkg.sv
// shared types and constants for the complex alu
package cau_pkg;

  localparam int CAU_FRAC_BITS = 16;
  localparam int CAU_QDEPTH    = 4;

  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_DIV  = 3'd3;
  localparam logic [2:0] OP_MAG  = 3'd4;
  localparam logic [2:0] OP_CONJ = 3'd5;

  typedef enum logic [1:0] {CLS_SIMPLE, CLS_MUL, CLS_DIV, CLS_ROOT} cls_t;

  typedef struct packed {
    cls_t               cls;
    logic               dz;
    logic [2:0]         op;
    logic signed [31:0] ar;
    logic signed [31:0] ai;
    logic signed [31:0] br;
    logic signed [31:0] bi;
  } entry_t;

endpackage

FILE: design/cau_front.sv
// front end: request queue that classifies each operation on entry
module cau_front import cau_pkg::*; #(
  parameter int DEPTH = CAU_QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               ent_valid,
  output entry_t             ent,
  input  logic               ent_take
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  entry_t          mem [DEPTH];
  logic [AW-1:0]   wr_ptr;
  logic [AW-1:0]   rd_ptr;
  logic [AW:0]     count;
  logic            push_ok;
  entry_t          in_ent;

  assign full      = (count == (AW+1)'(DEPTH));
  assign ent_valid = (count != '0);
  assign ent       = mem[rd_ptr];
  assign push_ok   = push && !full;

  always_comb begin
    in_ent.op = opcode;
    in_ent.ar = a_re;
    in_ent.ai = a_im;
    in_ent.br = b_re;
    in_ent.bi = b_im;
    in_ent.dz = 1'b0;
    case (opcode)
      OP_MUL: begin
        in_ent.cls = CLS_MUL;
      end
      OP_DIV: begin
        // zero divisor needs no engine, just a flagged zero result
        in_ent.dz  = (b_re == 32'sd0) && (b_im == 32'sd0);
        in_ent.cls = in_ent.dz ? CLS_SIMPLE : CLS_DIV;
      end
      OP_MAG: begin
        in_ent.cls = CLS_ROOT;
      end
      default: begin
        in_ent.cls = CLS_SIMPLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      mem[wr_ptr] <= in_ent;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (ent_take) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push_ok, ent_take})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/cau_back.sv
// back end: arithmetic engine with iterative divide and square root, result queue
module cau_back import cau_pkg::*; #(
  parameter int FRAC_BITS = CAU_FRAC_BITS
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               ent_valid,
  input  entry_t             ent,
  output logic               ent_take,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               div_by_zero,
  output logic               overflow
);

  localparam int NW = 64 + FRAC_BITS;
  localparam int CW = $clog2(NW);
  localparam logic [64:0] HALF = 65'(1) << (FRAC_BITS - 1);

  typedef enum logic [2:0] {S_IDLE, S_SUM, S_RND, S_DIV, S_ROOT, S_FIN} state_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
    logic               dz;
    logic               ov;
  } result_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [63:0]   rem;
    logic [33:0]   q;
    logic          big;
  } div_t;

  typedef struct packed {
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
  } root_t;

  // {ov, value}
  function automatic logic [32:0] sat_mag(input logic neg, input logic [63:0] q);
    logic [32:0] r;
    if (neg) begin
      if (q > 64'h8000_0000) r = {1'b1, 32'h8000_0000};
      else r = {1'b0, 32'(64'd0 - q)};
    end else begin
      if (q > 64'h7FFF_FFFF) r = {1'b1, 32'h7FFF_FFFF};
      else r = {1'b0, q[31:0]};
    end
    return r;
  endfunction

  function automatic logic [32:0] sat_sum(input logic [32:0] s);
    logic [32:0] r;
    if (s[32] && !s[31]) r = {1'b1, 32'h8000_0000};
    else if (!s[32] && s[31]) r = {1'b1, 32'h7FFF_FFFF};
    else r = {1'b0, s[31:0]};
    return r;
  endfunction

  // one restoring step: one quotient bit per cycle
  function automatic div_t div_step(input div_t s, input logic [63:0] d);
    div_t        n;
    logic [63:0] rsh;
    rsh   = {s.rem[62:0], s.num[NW-1]};
    n.num = {s.num[NW-2:0], 1'b0};
    n.big = s.big | s.q[33];
    n.q   = {s.q[32:0], 1'b0};
    if (rsh >= d) begin
      n.rem  = rsh - d;
      n.q[0] = 1'b1;
    end else begin
      n.rem = rsh;
    end
    return n;
  endfunction

  function automatic root_t root_step(input root_t s);
    root_t       n;
    logic [63:0] t;
    t = s.res + s.bitv;
    if (s.rem >= t) begin
      n.rem = s.rem - t;
      n.res = (s.res >> 1) + s.bitv;
    end else begin
      n.rem = s.rem;
      n.res = s.res >> 1;
    end
    n.bitv = s.bitv >> 2;
    return n;
  endfunction

  function automatic logic [32:0] div_fin(input div_t s, input logic neg, input logic [63:0] d);
    logic [34:0] qr;
    logic [63:0] qx;
    qr = {1'b0, s.q} + (({s.rem, 1'b0} >= {1'b0, d}) ? 35'd1 : 35'd0);
    qx = s.big ? 64'hFFFF_FFFF_FFFF_FFFF : 64'(qr);
    return sat_mag(neg, qx);
  endfunction

  state_t             state;
  cls_t               cls_q;
  logic signed [63:0] p0, p1, p2, p3, p4, p5;
  logic               neg_re, neg_im;
  logic [63:0]        mag_re, mag_im;
  logic [63:0]        d_q;
  div_t               dre, dim;
  root_t              rt;
  logic [CW-1:0]      cnt;

  result_t            oq [2];
  logic               owr, ord;
  logic [1:0]         ocnt;
  logic               out_space;
  logic               wr_en, rd_en;
  result_t            wr_data;

  logic signed [31:0] sq_x, sq_y;
  logic [32:0]        s_re, s_im, t_re, t_im, f_re, f_im;
  result_t            simple_res, mul_res, fin_res;
  logic signed [64:0] sum_re, sum_im;
  logic               neg_re_c, neg_im_c;
  logic [63:0]        mag_re_c, mag_im_c, dsum_c;
  logic [64:0]        qm_re, qm_im;
  logic [32:0]        u_re, u_im, root_r;
  logic [63:0]        root_q;

  assign out_space = (ocnt != 2'd2);
  assign empty     = (ocnt == 2'd0);
  assign rd_en     = pop && !empty;
  assign res_re      = oq[ord].re;
  assign res_im      = oq[ord].im;
  assign div_by_zero = oq[ord].dz;
  assign overflow    = oq[ord].ov;

  // operations finished in the issue cycle
  always_comb begin
    s_re = '0;
    s_im = '0;
    case (ent.op)
      OP_ADD: begin
        s_re = {ent.ar[31], ent.ar} + {ent.br[31], ent.br};
        s_im = {ent.ai[31], ent.ai} + {ent.bi[31], ent.bi};
      end
      OP_SUB: begin
        s_re = {ent.ar[31], ent.ar} - {ent.br[31], ent.br};
        s_im = {ent.ai[31], ent.ai} - {ent.bi[31], ent.bi};
      end
      OP_CONJ: begin
        s_re = {ent.ar[31], ent.ar};
        s_im = 33'd0 - {ent.ai[31], ent.ai};
      end
      default: begin
        s_re = '0;
        s_im = '0;
      end
    endcase
    t_re = sat_sum(s_re);
    t_im = sat_sum(s_im);
    if (ent.dz) begin
      simple_res = '{re: 32'sd0, im: 32'sd0, dz: 1'b1, ov: 1'b0};
    end else begin
      simple_res = '{re: t_re[31:0], im: t_im[31:0], dz: 1'b0, ov: t_re[32] | t_im[32]};
    end
  end

  assign sq_x = (ent.cls == CLS_ROOT) ? ent.ar : ent.br;
  assign sq_y = (ent.cls == CLS_ROOT) ? ent.ai : ent.bi;

  // combine products into exact sums as sign and magnitude
  always_comb begin
    if (cls_q == CLS_MUL) begin
      sum_re = {p0[63], p0} - {p1[63], p1};
      sum_im = {p2[63], p2} + {p3[63], p3};
    end else begin
      sum_re = {p0[63], p0} + {p1[63], p1};
      sum_im = {p3[63], p3} - {p2[63], p2};
    end
    neg_re_c = sum_re[64];
    neg_im_c = sum_im[64];
    mag_re_c = neg_re_c ? (~sum_re[63:0] + 64'd1) : sum_re[63:0];
    mag_im_c = neg_im_c ? (~sum_im[63:0] + 64'd1) : sum_im[63:0];
    dsum_c   = p4[63:0] + p5[63:0];
  end

  always_comb begin
    qm_re   = ({1'b0, mag_re} + HALF) >> FRAC_BITS;
    qm_im   = ({1'b0, mag_im} + HALF) >> FRAC_BITS;
    u_re    = sat_mag(neg_re, qm_re[63:0]);
    u_im    = sat_mag(neg_im, qm_im[63:0]);
    mul_res = '{re: u_re[31:0], im: u_im[31:0], dz: 1'b0, ov: u_re[32] | u_im[32]};
  end

  always_comb begin
    root_q = rt.res + ((rt.rem > rt.res) ? 64'd1 : 64'd0);
    root_r = sat_mag(1'b0, root_q);
    if (cls_q == CLS_DIV) begin
      f_re = div_fin(dre, neg_re, d_q);
      f_im = div_fin(dim, neg_im, d_q);
      fin_res = '{re: f_re[31:0], im: f_im[31:0], dz: 1'b0, ov: f_re[32] | f_im[32]};
    end else begin
      f_re = '0;
      f_im = '0;
      fin_res = '{re: root_r[31:0], im: 32'sd0, dz: 1'b0, ov: root_r[32]};
    end
  end

  always_comb begin
    ent_take = (state == S_IDLE) && ent_valid && ((ent.cls != CLS_SIMPLE) || out_space);
    wr_en    = ((state == S_IDLE) && ent_valid && (ent.cls == CLS_SIMPLE) && out_space)
            || (((state == S_RND) || (state == S_FIN)) && out_space);
    case (state)
      S_IDLE:  wr_data = simple_res;
      S_RND:   wr_data = mul_res;
      default: wr_data = fin_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      owr   <= 1'b0;
      ord   <= 1'b0;
      ocnt  <= 2'd0;
    end else begin
      if (wr_en) begin
        oq[owr] <= wr_data;
        owr     <= ~owr;
      end
      if (rd_en) begin
        ord <= ~ord;
      end
      case ({wr_en, rd_en})
        2'b10:   ocnt <= ocnt + 2'd1;
        2'b01:   ocnt <= ocnt - 2'd1;
        default: ocnt <= ocnt;
      endcase

      case (state)
        S_IDLE: begin
          if (ent_take && (ent.cls != CLS_SIMPLE)) begin
            p0    <= ent.ar * ent.br;
            p1    <= ent.ai * ent.bi;
            p2    <= ent.ar * ent.bi;
            p3    <= ent.ai * ent.br;
            p4    <= sq_x * sq_x;
            p5    <= sq_y * sq_y;
            cls_q <= ent.cls;
            state <= S_SUM;
          end
        end
        S_SUM: begin
          neg_re <= neg_re_c;
          neg_im <= neg_im_c;
          mag_re <= mag_re_c;
          mag_im <= mag_im_c;
          d_q    <= dsum_c;
          case (cls_q)
            CLS_MUL: begin
              state <= S_RND;
            end
            CLS_DIV: begin
              dre   <= '{num: {mag_re_c, {FRAC_BITS{1'b0}}}, rem: 64'd0, q: 34'd0, big: 1'b0};
              dim   <= '{num: {mag_im_c, {FRAC_BITS{1'b0}}}, rem: 64'd0, q: 34'd0, big: 1'b0};
              cnt   <= CW'(NW - 1);
              state <= S_DIV;
            end
            default: begin
              rt    <= '{rem: dsum_c, res: 64'd0, bitv: 64'h4000_0000_0000_0000};
              cnt   <= CW'(31);
              state <= S_ROOT;
            end
          endcase
        end
        S_DIV: begin
          dre <= div_step(dre, d_q);
          dim <= div_step(dim, d_q);
          if (cnt == '0) state <= S_FIN;
          else cnt <= cnt - CW'(1);
        end
        S_ROOT: begin
          rt <= root_step(rt);
          if (cnt == '0) state <= S_FIN;
          else cnt <= cnt - CW'(1);
        end
        S_RND, S_FIN: begin
          if (out_space) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: design/complex_arithmetic_unit_core.sv
// complex alu top level: request queue, engine and result queue
// usage:
//   requests enter through push/full with opcode and operands a, b (signed fixed point)
//   and are taken at an edge with push high and full low; a short queue holds them
//   while the engine works. results leave through empty/pop: the oldest result sits on
//   res_re, res_im, div_by_zero, overflow while empty is low, taken when pop is high.
// throughput and steps, from accept to empty low:
//   add, subtract, conjugate, unused codes, zero-divisor divide: one per cycle while
//   the result queue has space
//   multiply: engine busy for products, sums, round and saturate
//   magnitude: the square root unit retires one result bit per cycle
//   divide: both parts share 64 + FRAC_BITS restoring steps, one quotient bit per cycle
// results come out in request order; while pop stays low the two-entry result
// queue fills, the engine then holds, and the request queue raises full.
// reset (rst, synchronous) empties both queues and returns the engine to idle.
module complex_arithmetic_unit_core import cau_pkg::*; #(
  parameter int FRAC_BITS = CAU_FRAC_BITS,
  parameter int QDEPTH    = CAU_QDEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         opcode,
  input  logic signed [31:0] a_re,
  input  logic signed [31:0] a_im,
  input  logic signed [31:0] b_re,
  input  logic signed [31:0] b_im,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] res_re,
  output logic signed [31:0] res_im,
  output logic               div_by_zero,
  output logic               overflow
);

`include "complex_arithmetic_unit_core_macros.svh"

  logic   ent_valid;
  logic   ent_take;
  entry_t ent;

  cau_front #(.DEPTH(QDEPTH)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .opcode    (opcode),
    .a_re      (a_re),
    .a_im      (a_im),
    .b_re      (b_re),
    .b_im      (b_im),
    .ent_valid (ent_valid),
    .ent       (ent),
    .ent_take  (ent_take)
  );

  cau_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .ent_valid   (ent_valid),
    .ent         (ent),
    .ent_take    (ent_take),
    .empty       (empty),
    .pop         (pop),
    .res_re      (res_re),
    .res_im      (res_im),
    .div_by_zero (div_by_zero),
    .overflow    (overflow)
  );

  `CAU_ASSERT_IMP(a_dz_zero, !empty && div_by_zero, res_re == 32'sd0 && res_im == 32'sd0 && !overflow, "zero divisor result not clean")
  `CAU_ASSERT_IMP(a_take_valid, ent_take, ent_valid, "engine took from an empty request queue")
  `CAU_ASSERT_NXT(a_full_needs_push, !full && !push, !full, "full rose without a request")

endmodule
